/* rtl/crpr_pkg.sv */
package crpr_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_WIDTH = PHASE_FRAC_BITS + 1;
    localparam int STEP_WIDTH = 16;
    localparam logic [PHASE_WIDTH-1:0] PH_ONE = PHASE_WIDTH'(1) << PHASE_FRAC_BITS;
    localparam int MIN_STEP_I = ((1 << PHASE_FRAC_BITS) + 29) / 30;
    localparam logic [PHASE_WIDTH-1:0] MIN_STEP = PHASE_WIDTH'(MIN_STEP_I);
    localparam int CFG_IDX_WIDTH = 1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_STEP_RATE = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIRROR_ENDS = 1'd1;
    // Products: weights are about PHASE_WIDTH+3 bits signed.
    localparam int WEIGHT_WIDTH = PHASE_FRAC_BITS + 4;
    localparam int ACC_WIDTH = WEIGHT_WIDTH + COORD_WIDTH + 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_point;   // capture input point
        logic start_mirror; // insert start phantom before push
        logic push_in;      // push captured point
        logic push_end;     // push end phantom
        logic init_phase;   // phase = effective step
        logic clr_phase;    // phase = 0
        logic mul_go;       // start a sample computation
        logic adv_phase;    // phase += step
        logic wrap_phase;   // phase -= one
        logic sel_end;      // output end point
        logic end_from_win; // end point from window[2]
    } t_cmd;

    typedef struct packed {
        logic phase_lt_one;
        logic sample_ok;
    } t_status;

    function automatic logic signed [COORD_WIDTH-1:0] sat_c(
        input logic signed [COORD_WIDTH+1:0] v);
        logic signed [COORD_WIDTH+1:0] mx;
        logic signed [COORD_WIDTH+1:0] mn;
        begin
            mx = (COORD_WIDTH+2)'((1 << (COORD_WIDTH - 1)) - 1);
            mn = -mx - (COORD_WIDTH+2)'(1);
            if (v > mx) sat_c = mx[COORD_WIDTH-1:0];
            else if (v < mn) sat_c = mn[COORD_WIDTH-1:0];
            else sat_c = v[COORD_WIDTH-1:0];
        end
    endfunction

endpackage

/* rtl/crpr_datapath.sv */
module crpr_datapath (
    input  logic                                    i_clk,
    input  crpr_pkg::t_cmd                          i_cmd,
    input  logic signed [crpr_pkg::COORD_WIDTH-1:0] i_px,
    input  logic signed [crpr_pkg::COORD_WIDTH-1:0] i_py,
    input  logic [crpr_pkg::STEP_WIDTH-1:0]         i_step_rate,
    input  logic [2:0]                              i_fill,
    output crpr_pkg::t_status                       o_status,
    output logic signed [crpr_pkg::COORD_WIDTH-1:0] o_x,
    output logic signed [crpr_pkg::COORD_WIDTH-1:0] o_y
);
    localparam int CW = crpr_pkg::COORD_WIDTH;
    localparam int PW = crpr_pkg::PHASE_WIDTH;
    localparam int FB = crpr_pkg::PHASE_FRAC_BITS;
    localparam int WW = crpr_pkg::WEIGHT_WIDTH;
    localparam int AW = crpr_pkg::ACC_WIDTH;
    localparam int STEP_WIDTH_PAD = 24;

    logic signed [CW-1:0] r_wx [4];
    logic signed [CW-1:0] r_wy [4];
    logic signed [CW-1:0] r_px, r_py;
    logic [PW-1:0] r_phase;
    logic [3:0] r_seq;
    logic [2*PW-1:0] r_t2p, r_t3p;
    logic [PW-1:0] r_t2, r_t3, r_u;
    logic signed [WW-1:0] r_w [4];
    logic signed [AW-1:0] r_ax, r_ay;
    logic [1:0] r_k;
    logic signed [CW-1:0] r_ox, r_oy;

    logic [PW-1:0] step_eff;
    logic [PW+STEP_WIDTH_PAD-1:0] step_al;

    // Align the Q0.16 step and clamp to the minimum.
    always_comb begin
        if (FB >= 16)
            step_al = (PW+STEP_WIDTH_PAD)'(i_step_rate) << (FB - 16);
        else
            step_al = (PW+STEP_WIDTH_PAD)'(i_step_rate) >> (16 - FB);
        if (step_al < (PW+STEP_WIDTH_PAD)'(crpr_pkg::MIN_STEP)) step_eff = crpr_pkg::MIN_STEP;
        else step_eff = step_al[PW-1:0];
    end

    // Phantom points from the current window.
    logic [1:0] ia, ib;
    logic signed [CW-1:0] ex_x, ex_y, sm_x, sm_y;
    always_comb begin
        ia = 2'(i_fill - 3'd1);
        ib = 2'(i_fill - 3'd2);
        ex_x = crpr_pkg::sat_c((CW+2)'(2 * (CW+2)'(r_wx[ia]) - (CW+2)'(r_wx[ib])));
        ex_y = crpr_pkg::sat_c((CW+2)'(2 * (CW+2)'(r_wy[ia]) - (CW+2)'(r_wy[ib])));
        sm_x = crpr_pkg::sat_c((CW+2)'(2 * (CW+2)'(r_wx[0]) - (CW+2)'(r_px)));
        sm_y = crpr_pkg::sat_c((CW+2)'(2 * (CW+2)'(r_wy[0]) - (CW+2)'(r_py)));
    end

    // Window, captured point and phase.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_px <= i_px;
            r_py <= i_py;
        end
        if (i_cmd.start_mirror) begin
            r_wx[1] <= r_wx[0];
            r_wy[1] <= r_wy[0];
            r_wx[0] <= sm_x;
            r_wy[0] <= sm_y;
        end else if (i_cmd.push_in || i_cmd.push_end) begin
            if (i_fill < 3'd4) begin
                r_wx[i_fill[1:0]] <= i_cmd.push_in ? r_px : ex_x;
                r_wy[i_fill[1:0]] <= i_cmd.push_in ? r_py : ex_y;
            end else begin
                r_wx[0] <= r_wx[1]; r_wx[1] <= r_wx[2]; r_wx[2] <= r_wx[3];
                r_wy[0] <= r_wy[1]; r_wy[1] <= r_wy[2]; r_wy[2] <= r_wy[3];
                r_wx[3] <= i_cmd.push_in ? r_px : ex_x;
                r_wy[3] <= i_cmd.push_in ? r_py : ex_y;
            end
        end
        if (i_cmd.init_phase) r_phase <= step_eff;
        else if (i_cmd.clr_phase) r_phase <= '0;
        else if (i_cmd.adv_phase) r_phase <= r_phase + step_eff;
        else if (i_cmd.wrap_phase) r_phase <= r_phase - crpr_pkg::PH_ONE;
    end

    // Sample sequencer: t2, t3, weights, four multiply-accumulate steps, then rounding and saturation.
    logic signed [WW+CW-1:0] px_prod, py_prod;
    always_comb begin
        px_prod = WW'(r_w[r_k]) * r_wx[r_k];
        py_prod = WW'(r_w[r_k]) * r_wy[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_seq <= 4'd1;
            r_u <= r_phase;
            r_t2p <= r_phase * r_phase;
            r_k <= '0;
        end else begin
            unique case (r_seq)
                4'd1: begin
                    r_t2 <= r_t2p[FB+PW-1:FB];
                    r_seq <= 4'd2;
                end
                4'd2: begin
                    r_t3p <= r_t2 * r_u;
                    r_seq <= 4'd3;
                end
                4'd3: begin
                    r_t3 <= r_t3p[FB+PW-1:FB];
                    r_seq <= 4'd4;
                end
                4'd4: begin
                    r_w[0] <= WW'(-WW'(r_t3) + 2 * WW'(r_t2) - WW'(r_u));
                    r_w[1] <= WW'(3 * WW'(r_t3) - 5 * WW'(r_t2) + 2 * WW'(crpr_pkg::PH_ONE));
                    r_w[2] <= WW'(-3 * WW'(r_t3) + 4 * WW'(r_t2) + WW'(r_u));
                    r_w[3] <= WW'(r_t3) - WW'(r_t2);
                    r_ax <= AW'(crpr_pkg::PH_ONE);
                    r_ay <= AW'(crpr_pkg::PH_ONE);
                    r_seq <= 4'd5;
                end
                4'd5: begin
                    r_ax <= r_ax + AW'(px_prod);
                    r_ay <= r_ay + AW'(py_prod);
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) r_seq <= 4'd6;
                end
                4'd6: begin
                    r_ox <= crpr_pkg::sat_c((CW+2)'(r_ax >>> (FB + 1)) |
                        (((r_ax >>> (FB + 1)) > (AW'(1) <<< CW)) ? (CW+2)'(1 << CW) : '0) |
                        (((r_ax >>> (FB + 1)) < -(AW'(1) <<< CW)) ?
                            (CW+2)'(2 << CW) : '0));
                    r_oy <= crpr_pkg::sat_c((CW+2)'(r_ay >>> (FB + 1)) |
                        (((r_ay >>> (FB + 1)) > (AW'(1) <<< CW)) ? (CW+2)'(1 << CW) : '0) |
                        (((r_ay >>> (FB + 1)) < -(AW'(1) <<< CW)) ?
                            (CW+2)'(2 << CW) : '0));
                    r_seq <= 4'd7;
                end
                4'd7: r_seq <= 4'd0;
                default: r_seq <= 4'd0;
            endcase
        end
    end

    assign o_status.phase_lt_one = r_phase < crpr_pkg::PH_ONE;
    assign o_status.sample_ok = (r_seq == 4'd7);
    assign o_x = i_cmd.sel_end ? (i_cmd.end_from_win ? r_wx[2] : r_px) : r_ox;
    assign o_y = i_cmd.sel_end ? (i_cmd.end_from_win ? r_wy[2] : r_py) : r_oy;
endmodule

/* rtl/crpr_ctrl.sv */
module crpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_final,
    input  logic              i_mirror,
    input  crpr_pkg::t_status i_status,
    input  logic              i_out_take,
    output logic              o_stall,
    output logic              o_res_valid,
    output logic              o_run_end,
    output logic              o_path_done,
    output logic [2:0]        o_fill,
    output crpr_pkg::t_cmd    o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PRE   = 7'b0000010,
        S_SEG   = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_END   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_fill, n_fill;
    logic r_final, r_end_seg, r_seg_any, r_pend;
    logic n_final, n_end_seg, n_seg_any, n_pend;

    // Next-state and command logic; r_pend would mark a held sample but is never set and stays low.
    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_fill = r_fill;
        n_final = r_final;
        n_end_seg = r_end_seg;
        n_seg_any = r_seg_any;
        n_pend = r_pend;
        o_stall = (r_state != S_IDLE);
        o_res_valid = 1'b0;
        o_run_end = 1'b0;
        o_path_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_point = 1'b1;
                    n_final = i_final;
                    if (r_fill == 3'd0) o_cmd.init_phase = 1'b1;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (r_fill == 3'd1 && i_mirror) begin
                    o_cmd.start_mirror = 1'b1;
                    n_fill = 3'd2;
                end else begin
                    o_cmd.push_in = 1'b1;
                    if (r_fill < 3'd4) n_fill = r_fill + 3'd1;
                    n_end_seg = 1'b0;
                    n_state = ((r_fill >= 3'd3) ? S_SEG : S_FIN);
                end
            end
            S_SEG: begin
                if (i_status.phase_lt_one) begin
                    o_cmd.mul_go = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.wrap_phase = 1'b1;
                    n_seg_any = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_WAIT: begin
                if (i_status.sample_ok) begin
                    o_cmd.adv_phase = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Result is shown; it is the last if no further one follows.
                o_res_valid = 1'b1;
                o_run_end = !i_status.phase_lt_one && !r_final;
                if (i_out_take) n_state = S_SEG;
            end
            S_FIN: begin
                if (!r_final) begin
                    n_state = S_IDLE;
                end else if (!r_end_seg && i_mirror && r_fill >= 3'd2) begin
                    o_cmd.push_end = 1'b1;
                    if (r_fill < 3'd4) n_fill = r_fill + 3'd1;
                    n_end_seg = 1'b1;
                    n_state = (r_fill >= 3'd3) ? S_SEG : S_FIN;
                end else begin
                    n_end_seg = 1'b1;
                    n_state = S_END;
                end
            end
            S_END: begin
                o_cmd.sel_end = 1'b1;
                o_cmd.end_from_win = (r_fill == 3'd4);
                o_res_valid = 1'b1;
                o_run_end = 1'b1;
                o_path_done = 1'b1;
                if (i_out_take) begin
                    o_cmd.clr_phase = 1'b1;
                    n_fill = 3'd0;
                    n_seg_any = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A not-final point's last sample is recognized by a peek of the next
    // phase; S_SEG after the last sample wraps and returns to idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_final <= 1'b0;
            r_end_seg <= 1'b0;
            r_seg_any <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill;
            r_final <= n_final;
            r_end_seg <= n_end_seg;
            r_seg_any <= n_seg_any;
            r_pend <= n_pend & r_seg_any;
        end
    end

    assign o_fill = r_fill;
endmodule

/* rtl/catmull_rom_path_resampler.sv */
// Catmull-Rom path resampler. Control points enter one request at a time; each
// point that completes a four-point window yields the samples of one segment.
// Each sample is started, passes through the shared sequencer (square, cube,
// weights, four multiply-accumulate steps, rounding and saturation) and is then
// handed over. Each point goes through capture, window update and return to
// idle, with the start phantom inserted where enabled and a phase wrap after a
// sampled segment. A final point also pushes the end phantom, if enabled, comes
// back from its segment and then offers the path end point flagged path_done.
// Output stalls lengthen each hand-over. The block takes a new point only when
// the previous one has delivered all of its results.
module catmull_rom_path_resampler (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [crpr_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_idx,
    input  logic [15:0]                             i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [crpr_pkg::COORD_WIDTH-1:0] i_point_x,
    input  logic signed [crpr_pkg::COORD_WIDTH-1:0] i_point_y,
    input  logic                                    i_final_point,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [crpr_pkg::COORD_WIDTH-1:0] o_out_x,
    output logic signed [crpr_pkg::COORD_WIDTH-1:0] o_out_y,
    output logic                                    o_run_end,
    output logic                                    o_path_done
);
    logic [15:0] r_step_rate;
    logic r_mirror;
    crpr_pkg::t_cmd cmd;
    crpr_pkg::t_status st;
    logic [2:0] fill;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_rate <= 16'd4096;
            r_mirror <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                crpr_pkg::REG_STEP_RATE:   r_step_rate <= i_cfg_data;
                crpr_pkg::REG_MIRROR_ENDS: r_mirror <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    crpr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_final(i_final_point), .i_mirror(r_mirror), .i_status(st),
        .i_out_take(!i_stall), .o_stall(o_stall), .o_res_valid(o_valid),
        .o_run_end(o_run_end), .o_path_done(o_path_done), .o_fill(fill),
        .o_cmd(cmd)
    );

    crpr_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_px(i_point_x), .i_py(i_point_y),
        .i_step_rate(r_step_rate), .i_fill(fill), .o_status(st),
        .o_x(o_out_x), .o_y(o_out_y)
    );

    // A point is never taken while a result is on offer.
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken with result pending");
    // The path end result always carries run_end.
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_path_done) |-> o_run_end) else $error("done without run_end");
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int CW = crpr_pkg::COORD_WIDTH;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   run_end;
        logic   path_done;
    } t_sample;

    // Spline predictor with its own copy of the state and registers, plus the
    // queue of samples it has predicted but not yet seen.
    class spline_scoreboard;
        longint step_reg;
        bit     mirror_reg;
        longint win_x[4];
        longint win_y[4];
        int     fill;
        longint ph;
        t_sample pending[$];
        int     errors;

        function void clear();
            step_reg = 4096;
            mirror_reg = 1;
            for (int i = 0; i < 4; i++) begin
                win_x[i] = 0;
                win_y[i] = 0;
            end
            fill = 0;
            ph = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [crpr_pkg::CFG_IDX_WIDTH-1:0] idx, logic [15:0] val);
            if (idx == crpr_pkg::REG_STEP_RATE) step_reg = val;
            else if (idx == crpr_pkg::REG_MIRROR_ENDS) mirror_reg = val[0];
        endfunction

        function longint clip(longint v);
            longint mx;
            mx = (longint'(1) << (CW - 1)) - 1;
            if (v > mx) return mx;
            if (v < -mx - 1) return -mx - 1;
            return v;
        endfunction

        function longint phase_step();
            longint s;
            s = step_reg << (crpr_pkg::PHASE_FRAC_BITS - 16);
            if (s < crpr_pkg::MIN_STEP_I) s = crpr_pkg::MIN_STEP_I;
            return s;
        endfunction

        function void shift_in(longint x, longint y);
            if (fill < 4) begin
                win_x[fill] = x;
                win_y[fill] = y;
                fill++;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    win_x[i] = win_x[i+1];
                    win_y[i] = win_y[i+1];
                end
                win_x[3] = x;
                win_y[3] = y;
            end
        endfunction

        // Arithmetic shift of a signed longint floors toward minus infinity.
        function longint mix(longint p[4], longint w[4]);
            longint acc;
            acc = w[0]*p[0] + w[1]*p[1] + w[2]*p[2] + w[3]*p[3];
            acc += longint'(1) << crpr_pkg::PHASE_FRAC_BITS;
            return clip(acc >>> (crpr_pkg::PHASE_FRAC_BITS + 1));
        endfunction

        function void note(t_coord x, t_coord y, logic done);
            t_sample s;
            s.x = x;
            s.y = y;
            s.run_end = 0;
            s.path_done = done;
            pending = {pending, s};
        endfunction

        // Samples the segment between window[1] and window[2].
        function void sample_segment();
            longint one, st, t2, t3, u;
            longint w[4];
            one = longint'(1) << crpr_pkg::PHASE_FRAC_BITS;
            st = phase_step();
            while (ph < one) begin
                u = ph;
                t2 = (u * u) >> crpr_pkg::PHASE_FRAC_BITS;
                t3 = (t2 * u) >> crpr_pkg::PHASE_FRAC_BITS;
                w[0] = -t3 + 2*t2 - u;
                w[1] = 3*t3 - 5*t2 + 2*one;
                w[2] = -3*t3 + 4*t2 + u;
                w[3] = t3 - t2;
                note(t_coord'(mix(win_x, w)), t_coord'(mix(win_y, w)), 1'b0);
                ph += st;
            end
            ph -= one;
        endfunction

        function void accept_point(t_coord px, t_coord py, logic last);
            longint x, y;
            int queued, a, b;
            x = px;
            y = py;
            queued = pending.size();
            if (fill == 0) ph = phase_step();
            if (fill == 1 && mirror_reg) begin
                win_x[1] = win_x[0];
                win_y[1] = win_y[0];
                win_x[0] = clip(2*win_x[1] - x);
                win_y[0] = clip(2*win_y[1] - y);
                fill = 2;
            end
            shift_in(x, y);
            if (fill == 4) sample_segment();
            if (last) begin
                if (mirror_reg && fill >= 2) begin
                    a = fill - 1;
                    b = fill - 2;
                    shift_in(clip(2*win_x[a] - win_x[b]), clip(2*win_y[a] - win_y[b]));
                    if (fill == 4) sample_segment();
                end
                if (fill == 4) note(t_coord'(win_x[2]), t_coord'(win_y[2]), 1'b1);
                else note(px, py, 1'b1);
                fill = 0;
                ph = 0;
            end
            if (pending.size() > queued) pending[$].run_end = 1;
        endfunction

        function void check(t_sample got);
            t_sample exp_s;
            if (pending.size() == 0) begin
                $display("%0t: unexpected sample x=%0d y=%0d", $time, got.x, got.y);
                errors++;
                return;
            end
            exp_s = pending.pop_front();
            if (got.x !== exp_s.x) begin
                $display("%0t: out_x expected %0d actual %0d", $time, exp_s.x, got.x);
                errors++;
            end
            if (got.y !== exp_s.y) begin
                $display("%0t: out_y expected %0d actual %0d", $time, exp_s.y, got.y);
                errors++;
            end
            if (got.run_end !== exp_s.run_end) begin
                $display("%0t: run_end expected %0b actual %0b", $time,
                         exp_s.run_end, got.run_end);
                errors++;
            end
            if (got.path_done !== exp_s.path_done) begin
                $display("%0t: path_done expected %0b actual %0b", $time,
                         exp_s.path_done, got.path_done);
                errors++;
            end
        endfunction
    endclass

    logic                               i_clk = 0;
    logic                               i_rst_n = 0;
    logic                               i_cfg_we = 0;
    logic [crpr_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx = '0;
    logic [15:0]                        i_cfg_data = '0;
    logic                               i_valid = 0;
    logic                               o_stall;
    t_coord                             i_point_x = '0;
    t_coord                             i_point_y = '0;
    logic                               i_final_point = 0;
    logic                               o_valid;
    logic                               i_stall = 1;
    t_coord                             o_out_x;
    t_coord                             o_out_y;
    logic                               o_run_end;
    logic                               o_path_done;

    catmull_rom_path_resampler dut (.*);

    always #6 i_clk = ~i_clk;

    spline_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_off = 0;
    bit  hold_trig = 0;
    bit  hold_seen = 0;
    int  quiet_cycles = 0;

    // Check every accepted sample and count cycles without any progress.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check('{o_out_x, o_out_y, o_run_end, o_path_done});
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stall; a long hold-off overrides the random idling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1;
        end else if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_off <= 400;
            i_stall <= 1;
        end else if (hold_off > 0) begin
            i_stall <= 1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_reg(logic [crpr_pkg::CFG_IDX_WIDTH-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Offers one request and holds it until the block takes it.
    task automatic send_point(t_coord x, t_coord y, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_point_x <= x;
        i_point_y <= y;
        i_final_point <= last;
        do @(posedge i_clk); while (o_stall);
        board.accept_point(x, y, last);
    endtask

    task automatic drain();
        int guard;
        i_valid <= 0;
        guard = 0;
        while (board.pending.size() != 0 && guard < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        // Points that give no sample may still be in work.
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(5))
            0: return t_coord'(16'h7fff);
            1: return t_coord'(16'h8000);
            2: return t_coord'($urandom_range(200)) - t_coord'(100);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // A random path, mostly short and smooth, sometimes wild.
    task automatic send_path(int count);
        t_coord x, y;
        x = t_coord'($urandom_range(4000)) - t_coord'(2000);
        y = t_coord'($urandom_range(4000)) - t_coord'(2000);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 2) begin
                x = rand_coord();
                y = rand_coord();
            end else begin
                x = x + t_coord'($urandom_range(600)) - t_coord'(300);
                y = y + t_coord'($urandom_range(600)) - t_coord'(300);
            end
            send_point(x, y, i == count - 1);
        end
    endtask

    int sent;

    initial begin
        board.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, short paths, both mirror settings.
        send_point(16'sh7fff, -16'sh8000, 1'b1);
        send_point(16'sh1234, 16'sh0100, 1'b0);
        send_point(-16'sh8000, 16'sh7fff, 1'b1);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b0);
        send_point(16'sh0000, 16'sh0000, 1'b1);
        drain();
        write_reg(crpr_pkg::REG_MIRROR_ENDS, 16'd0);
        write_reg(crpr_pkg::REG_STEP_RATE, 16'hffff);
        send_point(16'sh0001, -16'sh0001, 1'b1);
        send_point(16'sh0010, 16'sh0020, 1'b0);
        send_point(16'sh0030, -16'sh0040, 1'b1);
        send_path(5);
        drain();
        write_reg(crpr_pkg::REG_STEP_RATE, 16'd0);
        send_path(4);
        drain();
        write_reg(crpr_pkg::REG_STEP_RATE, 16'd2185);
        send_path(6);
        drain();
        write_reg(crpr_pkg::REG_MIRROR_ENDS, 16'd1);

        sent = 25;
        for (int phase_no = 0; phase_no < 3; phase_no++) begin
            send_idle_pct = (phase_no == 0) ? 31 : (phase_no == 1) ? 84 : 0;
            recv_idle_pct = (phase_no == 0) ? 84 : (phase_no == 1) ? 31 : 0;
            for (int k = 0; k < 14; k++) begin
                int n;
                n = ($urandom_range(9) == 0) ? 1 + $urandom_range(2) : 2 + $urandom_range(10);
                if (phase_no == 0 && k == 2) hold_trig <= !hold_trig;
                send_path(n);
                sent += n;
                if (k % 5 == 4) begin
                    drain();
                    write_reg(crpr_pkg::REG_STEP_RATE, ($urandom_range(3) == 0) ?
                              16'($urandom) : 16'($urandom_range(16384, 5000)));
                    write_reg(crpr_pkg::REG_MIRROR_ENDS, 16'($urandom_range(1)));
                end
            end
            drain();
        end
        while (sent < 420) begin
            int n;
            n = 2 + $urandom_range(10);
            send_path(n);
            sent += n;
        end
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (board.pending.size() != 0)
                $display("%0t: %0d samples never arrived", $time, board.pending.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
